// ===== design/owb_pkg.sv =====
// Shared types, command bytes and the CRC-16 byte update for the 1-Wire EEPROM block writer.
// Used by owb_seq, the top level and the checker; depends on nothing.
`default_nettype none

package owb_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int BLOCK_BYTES_DEF  = 8;
    localparam int BUFFER_BYTES_DEF = 32;

    // Item modes.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_ADDR = 2'd0;
    localparam logic [1:0] CFG_COPY_WAIT  = 2'd1;
    localparam logic [1:0] CFG_BLOCKS     = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  START_ADDR_RST = 8'h20;
    localparam logic [15:0] COPY_WAIT_RST  = 16'd20;
    localparam logic [2:0]  BLOCKS_RST     = 3'd4;

    // Bridge and 1-Wire command bytes.
    localparam logic [7:0] CMD_RESET_PULSE   = 8'hC1;
    localparam logic [7:0] CMD_DATA_MODE     = 8'hE1;
    localparam logic [7:0] CMD_COMMAND_MODE  = 8'hE3;
    localparam logic [7:0] CMD_SKIP_ROM      = 8'hCC;
    localparam logic [7:0] CMD_WRITE_SCRATCH = 8'h0F;
    localparam logic [7:0] CMD_COPY_SCRATCH  = 8'h55;
    localparam logic [7:0] CMD_COPY_AUTH     = 8'h07;
    localparam logic [7:0] READ_SLOT         = 8'hFF;
    localparam logic [7:0] ADDR_HIGH_BYTE    = 8'h00;
    localparam logic [7:0] STATUS_OK         = 8'hAA;
    localparam logic [7:0] RESET_REPLY_MASK  = 8'hDF;
    localparam logic [7:0] RESET_REPLY       = 8'hCD;

    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic       mode;
        logic [4:0] load_index;
        logic [7:0] load_value;
        logic       answer_valid;
        logic [7:0] answer_byte;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       clear_answer;
        logic       write_done;
        logic       write_failed;
    } result_t;

    typedef struct packed {
        logic [7:0]  start_address_low;
        logic [15:0] copy_wait_ticks;
        logic [2:0]  block_count;
    } cfg_t;

    typedef enum logic [7:0] {
        M_RESET      = 8'b0000_0001,
        M_WAIT_RESET = 8'b0000_0010,
        M_DATA_MODE  = 8'b0000_0100,
        M_WAIT_SKIP  = 8'b0000_1000,
        M_ADDR_LOW   = 8'b0001_0000,
        M_ADDR_HIGH  = 8'b0010_0000,
        M_BLOCK      = 8'b0100_0000,
        M_FAIL       = 8'b1000_0000
    } main_step_t;

    typedef enum logic [13:0] {
        C_CRC_LOW       = 14'b00_0000_0000_0001,
        C_WAIT_CRC_LOW  = 14'b00_0000_0000_0010,
        C_CRC_HIGH      = 14'b00_0000_0000_0100,
        C_WAIT_CRC_HIGH = 14'b00_0000_0000_1000,
        C_CMD_MODE      = 14'b00_0000_0001_0000,
        C_RESET         = 14'b00_0000_0010_0000,
        C_WAIT_RESET    = 14'b00_0000_0100_0000,
        C_DATA_MODE     = 14'b00_0000_1000_0000,
        C_WAIT_SKIP     = 14'b00_0001_0000_0000,
        C_ADDR_LOW      = 14'b00_0010_0000_0000,
        C_ADDR_HIGH     = 14'b00_0100_0000_0000,
        C_AUTH          = 14'b00_1000_0000_0000,
        C_WAIT_COPY     = 14'b01_0000_0000_0000,
        C_WAIT_STATUS   = 14'b10_0000_0000_0000
    } copy_step_t;

    // Reflected CRC-16, one byte: eight shift steps on a 16-bit value.
    function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/owb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the block writer's data buffer.
`default_nettype none

module owb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when both ports hit the same address.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/owb_seq.sv =====
// Write sequencer of the 1-Wire EEPROM block writer: run state and one tick of step logic.
// Depends on owb_pkg; the buffer byte comes from the RAM in the top level.
`default_nettype none

module owb_seq #(
    parameter int BLOCK_BYTES  = owb_pkg::BLOCK_BYTES_DEF,
    parameter int BUFFER_BYTES = owb_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            step_en,
    input  wire owb_pkg::item_t                  item,
    input  wire owb_pkg::cfg_t                   cfg,
    input  wire logic [7:0]                      data_byte,
    output logic      [$clog2(BUFFER_BYTES)-1:0] rd_index,
    output logic      [$clog2(BUFFER_BYTES)-1:0] rd_index_next,
    output owb_pkg::result_t                     result
);

    localparam int IDXW = $clog2(BUFFER_BYTES);

    owb_pkg::main_step_t main_step_reg, main_step_next;
    owb_pkg::copy_step_t copy_step_reg, copy_step_next;
    logic                scratch_full_reg, scratch_full_next;
    logic [7:0]          block_address_reg, block_address_next;
    logic [2:0]          block_number_reg, block_number_next;
    logic [IDXW-1:0]     byte_index_reg, byte_index_next;
    logic [15:0]         running_crc_reg, running_crc_next;
    logic [15:0]         wait_counter_reg, wait_counter_next;

    logic [BUFFER_BYTES-1:0] block_boundary;
    logic [IDXW-1:0]         index_inc;
    logic [2:0]              block_inc;
    logic                    reset_reply_ok;
    logic                    skip_echo_ok;

    // Buffer positions that start a block, fixed at elaboration.
    for (genvar i = 0; i < BUFFER_BYTES; i++)
    begin : g_boundary
        assign block_boundary[i] = ((i % BLOCK_BYTES) == 0);
    end

    assign index_inc = (byte_index_reg == IDXW'(BUFFER_BYTES - 1)) ? '0 : byte_index_reg + 1'b1;
    assign block_inc = block_number_reg + 3'd1;
    assign reset_reply_ok = item.answer_valid &&
        ((item.answer_byte & owb_pkg::RESET_REPLY_MASK) == owb_pkg::RESET_REPLY);
    assign skip_echo_ok = item.answer_valid && (item.answer_byte == owb_pkg::CMD_SKIP_ROM);

    always_comb
    begin
        main_step_next     = main_step_reg;
        copy_step_next     = copy_step_reg;
        scratch_full_next  = scratch_full_reg;
        block_address_next = block_address_reg;
        block_number_next  = block_number_reg;
        byte_index_next    = byte_index_reg;
        running_crc_next   = running_crc_reg;
        wait_counter_next  = wait_counter_reg;
        result             = '0;

        if (step_en && (item.mode == owb_pkg::MODE_TICK))
        begin
            unique case (main_step_reg)
                owb_pkg::M_RESET:
                begin
                    result.clear_answer = 1'b1;
                    result.tx_valid     = 1'b1;
                    result.tx_byte      = owb_pkg::CMD_RESET_PULSE;
                    main_step_next      = owb_pkg::M_WAIT_RESET;
                end
                owb_pkg::M_WAIT_RESET:
                begin
                    if (reset_reply_ok)
                    begin
                        result.tx_valid = 1'b1;
                        result.tx_byte  = owb_pkg::CMD_DATA_MODE;
                        main_step_next  = owb_pkg::M_DATA_MODE;
                    end
                    else
                    begin
                        main_step_next = owb_pkg::M_FAIL;
                    end
                end
                owb_pkg::M_DATA_MODE:
                begin
                    result.clear_answer = 1'b1;
                    result.tx_valid     = 1'b1;
                    result.tx_byte      = owb_pkg::CMD_SKIP_ROM;
                    main_step_next      = owb_pkg::M_WAIT_SKIP;
                end
                owb_pkg::M_WAIT_SKIP:
                begin
                    if (skip_echo_ok)
                    begin
                        result.tx_valid  = 1'b1;
                        result.tx_byte   = owb_pkg::CMD_WRITE_SCRATCH;
                        running_crc_next = owb_pkg::crc16_add(16'h0000,
                                                              owb_pkg::CMD_WRITE_SCRATCH);
                        main_step_next   = owb_pkg::M_ADDR_LOW;
                    end
                    else
                    begin
                        main_step_next = owb_pkg::M_FAIL;
                    end
                end
                owb_pkg::M_ADDR_LOW:
                begin
                    result.tx_valid  = 1'b1;
                    result.tx_byte   = block_address_reg;
                    running_crc_next = owb_pkg::crc16_add(running_crc_reg, block_address_reg);
                    main_step_next   = owb_pkg::M_ADDR_HIGH;
                end
                owb_pkg::M_ADDR_HIGH:
                begin
                    result.tx_valid  = 1'b1;
                    result.tx_byte   = owb_pkg::ADDR_HIGH_BYTE;
                    running_crc_next = owb_pkg::crc16_add(running_crc_reg,
                                                          owb_pkg::ADDR_HIGH_BYTE);
                    main_step_next   = owb_pkg::M_BLOCK;
                end
                owb_pkg::M_BLOCK:
                begin
                    if (!scratch_full_reg)
                    begin
                        // Data phase: one buffer byte per tick until a block boundary.
                        result.tx_valid  = 1'b1;
                        result.tx_byte   = data_byte;
                        running_crc_next = owb_pkg::crc16_add(running_crc_reg, data_byte);
                        byte_index_next  = index_inc;
                        if (block_boundary[index_inc])
                        begin
                            scratch_full_next = 1'b1;
                            copy_step_next    = owb_pkg::C_CRC_LOW;
                        end
                    end
                    else
                    begin
                        unique case (copy_step_reg)
                            owb_pkg::C_CRC_LOW:
                            begin
                                result.clear_answer = 1'b1;
                                result.tx_valid     = 1'b1;
                                result.tx_byte      = owb_pkg::READ_SLOT;
                                running_crc_next    = ~running_crc_reg;
                                copy_step_next      = owb_pkg::C_WAIT_CRC_LOW;
                            end
                            owb_pkg::C_WAIT_CRC_LOW:
                            begin
                                if (item.answer_valid &&
                                    (item.answer_byte == running_crc_reg[7:0]))
                                begin
                                    copy_step_next = owb_pkg::C_CRC_HIGH;
                                end
                                else
                                begin
                                    main_step_next = owb_pkg::M_FAIL;
                                end
                            end
                            owb_pkg::C_CRC_HIGH:
                            begin
                                result.clear_answer = 1'b1;
                                result.tx_valid     = 1'b1;
                                result.tx_byte      = owb_pkg::READ_SLOT;
                                copy_step_next      = owb_pkg::C_WAIT_CRC_HIGH;
                            end
                            owb_pkg::C_WAIT_CRC_HIGH:
                            begin
                                if (item.answer_valid &&
                                    (item.answer_byte == running_crc_reg[15:8]))
                                begin
                                    copy_step_next = owb_pkg::C_CMD_MODE;
                                end
                                else
                                begin
                                    main_step_next = owb_pkg::M_FAIL;
                                end
                            end
                            owb_pkg::C_CMD_MODE:
                            begin
                                result.tx_valid = 1'b1;
                                result.tx_byte  = owb_pkg::CMD_COMMAND_MODE;
                                copy_step_next  = owb_pkg::C_RESET;
                            end
                            owb_pkg::C_RESET:
                            begin
                                result.clear_answer = 1'b1;
                                result.tx_valid     = 1'b1;
                                result.tx_byte      = owb_pkg::CMD_RESET_PULSE;
                                copy_step_next      = owb_pkg::C_WAIT_RESET;
                            end
                            owb_pkg::C_WAIT_RESET:
                            begin
                                if (reset_reply_ok)
                                begin
                                    result.tx_valid = 1'b1;
                                    result.tx_byte  = owb_pkg::CMD_DATA_MODE;
                                    copy_step_next  = owb_pkg::C_DATA_MODE;
                                end
                                else
                                begin
                                    main_step_next = owb_pkg::M_FAIL;
                                end
                            end
                            owb_pkg::C_DATA_MODE:
                            begin
                                result.clear_answer = 1'b1;
                                result.tx_valid     = 1'b1;
                                result.tx_byte      = owb_pkg::CMD_SKIP_ROM;
                                copy_step_next      = owb_pkg::C_WAIT_SKIP;
                            end
                            owb_pkg::C_WAIT_SKIP:
                            begin
                                if (skip_echo_ok)
                                begin
                                    result.tx_valid = 1'b1;
                                    result.tx_byte  = owb_pkg::CMD_COPY_SCRATCH;
                                    copy_step_next  = owb_pkg::C_ADDR_LOW;
                                end
                                else
                                begin
                                    main_step_next = owb_pkg::M_FAIL;
                                end
                            end
                            owb_pkg::C_ADDR_LOW:
                            begin
                                result.tx_valid = 1'b1;
                                result.tx_byte  = block_address_reg;
                                copy_step_next  = owb_pkg::C_ADDR_HIGH;
                            end
                            owb_pkg::C_ADDR_HIGH:
                            begin
                                result.tx_valid = 1'b1;
                                result.tx_byte  = owb_pkg::ADDR_HIGH_BYTE;
                                copy_step_next  = owb_pkg::C_AUTH;
                            end
                            owb_pkg::C_AUTH:
                            begin
                                result.tx_valid   = 1'b1;
                                result.tx_byte    = owb_pkg::CMD_COPY_AUTH;
                                wait_counter_next = cfg.copy_wait_ticks;
                                copy_step_next    = owb_pkg::C_WAIT_COPY;
                            end
                            owb_pkg::C_WAIT_COPY:
                            begin
                                if (wait_counter_reg == 16'd0)
                                begin
                                    result.clear_answer = 1'b1;
                                    result.tx_valid     = 1'b1;
                                    result.tx_byte      = owb_pkg::READ_SLOT;
                                    copy_step_next      = owb_pkg::C_WAIT_STATUS;
                                end
                                else
                                begin
                                    wait_counter_next = wait_counter_reg - 16'd1;
                                end
                            end
                            owb_pkg::C_WAIT_STATUS:
                            begin
                                if (item.answer_valid &&
                                    (item.answer_byte == owb_pkg::STATUS_OK))
                                begin
                                    result.tx_valid   = 1'b1;
                                    result.tx_byte    = owb_pkg::CMD_COMMAND_MODE;
                                    main_step_next    = owb_pkg::M_RESET;
                                    scratch_full_next = 1'b0;
                                    if (block_inc >= cfg.block_count)
                                    begin
                                        // Last block copied: finish and rewind the run.
                                        result.write_done  = 1'b1;
                                        byte_index_next    = '0;
                                        block_address_next = cfg.start_address_low;
                                        block_number_next  = 3'd0;
                                    end
                                    else
                                    begin
                                        block_address_next = block_address_reg +
                                                             8'(BLOCK_BYTES);
                                        block_number_next  = block_inc;
                                    end
                                end
                                else
                                begin
                                    main_step_next = owb_pkg::M_FAIL;
                                end
                            end
                            default:
                            begin
                                copy_step_next = copy_step_reg;
                            end
                        endcase
                    end
                end
                owb_pkg::M_FAIL:
                begin
                    result.write_failed = 1'b1;
                    main_step_next      = owb_pkg::M_RESET;
                    byte_index_next     = '0;
                    block_address_next  = cfg.start_address_low;
                    scratch_full_next   = 1'b0;
                    block_number_next   = 3'd0;
                end
                default:
                begin
                    main_step_next = main_step_reg;
                end
            endcase
        end
    end

    assign rd_index      = byte_index_reg;
    assign rd_index_next = byte_index_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_step_reg     <= owb_pkg::M_RESET;
            copy_step_reg     <= owb_pkg::C_CRC_LOW;
            scratch_full_reg  <= 1'b0;
            block_address_reg <= owb_pkg::START_ADDR_RST;
            block_number_reg  <= 3'd0;
            byte_index_reg    <= '0;
            running_crc_reg   <= 16'h0000;
            wait_counter_reg  <= 16'd0;
        end
        else
        begin
            main_step_reg     <= main_step_next;
            copy_step_reg     <= copy_step_next;
            scratch_full_reg  <= scratch_full_next;
            block_address_reg <= block_address_next;
            block_number_reg  <= block_number_next;
            byte_index_reg    <= byte_index_next;
            running_crc_reg   <= running_crc_next;
            wait_counter_reg  <= wait_counter_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/onewire_eeprom_block_writer.sv =====
// Top level of the 1-Wire EEPROM block writer: channel registers, configuration, data buffer.
// Depends on owb_pkg, owb_ram and owb_seq.
//
// Usage:
//   The input channel (item_valid, item_stall, item) carries either a load item, which stores
//   one byte into the data buffer, or a sequencer tick, which may carry the last reply byte
//   from the serial bridge. Every item gives exactly one result on the output channel
//   (result_valid, result_stall, result): at most one byte to transmit, a request to clear the
//   bridge's reply flag, and the run-finished or run-failed flags. Load items give an all-zero
//   result. A transfer happens on a rising edge with valid high and stall low.
//
//   An item is captured in the input register, processed from there, and its result sits in
//   the result register until it is taken. Throughput is one item per cycle while the result
//   register is not stalled; the CRC-16 update is an eight-step shift chain between the two
//   registers and the buffer is a RAM read ahead of use, so nothing iterates.
//   When the receiver stalls, the result register holds its transfer and the input register
//   still takes one more item; only then is item_stall raised.
//
//   Reset clears both channel registers, loads the configuration defaults (start address
//   0x20, 20 copy-wait ticks, four blocks) and rewinds the run. The buffer holds no defined
//   value until loaded. Configuration writes via cfg_we/cfg_index/cfg_wdata take effect at
//   once and are meant for times when no item is in flight.
`default_nettype none

module onewire_eeprom_block_writer #(
    parameter int BLOCK_BYTES  = owb_pkg::BLOCK_BYTES_DEF,
    parameter int BUFFER_BYTES = owb_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire owb_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output owb_pkg::result_t      result,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [15:0]      cfg_wdata
);

    localparam int IDXW = $clog2(BUFFER_BYTES);

    // Channel registers.
    logic             in_valid_reg;
    owb_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    owb_pkg::result_t out_item_reg;
    logic             advance;

    // Configuration.
    owb_pkg::cfg_t    cfg_reg;

    // Buffer access.
    logic [IDXW-1:0]  load_map [32];
    logic             wr_en;
    logic [IDXW-1:0]  wr_addr;
    logic [IDXW-1:0]  rd_index;
    logic [IDXW-1:0]  rd_index_next;
    logic [7:0]       rd_data;
    logic [7:0]       data_byte;
    logic             byp_valid_reg;
    logic [IDXW-1:0]  byp_addr_reg;
    logic [7:0]       byp_data_reg;

    owb_pkg::result_t step_result;

    // The item in the input register is processed whenever the result register can take it.
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= step_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_address_low <= owb_pkg::START_ADDR_RST;
            cfg_reg.copy_wait_ticks   <= owb_pkg::COPY_WAIT_RST;
            cfg_reg.block_count       <= owb_pkg::BLOCKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                owb_pkg::CFG_START_ADDR: cfg_reg.start_address_low <= cfg_wdata[7:0];
                owb_pkg::CFG_COPY_WAIT:  cfg_reg.copy_wait_ticks   <= cfg_wdata;
                owb_pkg::CFG_BLOCKS:     cfg_reg.block_count       <= cfg_wdata[2:0];
                default:                 cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // Load index folded into the buffer depth, worked out at elaboration.
    for (genvar i = 0; i < 32; i++)
    begin : g_load_map
        assign load_map[i] = IDXW'(i % BUFFER_BYTES);
    end

    assign wr_en   = advance && (in_item_reg.mode == owb_pkg::MODE_LOAD);
    assign wr_addr = load_map[in_item_reg.load_index];

    // The RAM is read at the next byte index every cycle, so the data for the current index
    // is ready when a tick arrives. A load into that same index at the previous edge is not
    // yet visible in the read data and is forwarded from the bypass register instead.
    owb_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_buffer (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_item_reg.load_value),
        .rd_addr (rd_index_next),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            byp_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byp_addr_reg <= wr_addr;
            byp_data_reg <= in_item_reg.load_value;
        end
    end

    assign data_byte = (byp_valid_reg && (byp_addr_reg == rd_index)) ? byp_data_reg : rd_data;

    owb_seq #(
        .BLOCK_BYTES  (BLOCK_BYTES),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (advance),
        .item          (in_item_reg),
        .cfg           (cfg_reg),
        .data_byte     (data_byte),
        .rd_index      (rd_index),
        .rd_index_next (rd_index_next),
        .result        (step_result)
    );

endmodule

`default_nettype wire

// ===== design/owb_checker.sv =====
// Port-level checks for the 1-Wire EEPROM block writer, bound to the top level.
// Depends on owb_pkg and onewire_eeprom_block_writer.
`default_nettype none

module owb_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire owb_pkg::result_t result
);

    // A stalled result holds until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // A finished run always ends by sending the command-mode byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.write_done |->
            result.tx_valid && (result.tx_byte == owb_pkg::CMD_COMMAND_MODE) &&
            !result.write_failed)
        else $error("run finished without command-mode byte");

    // A failure tick sends nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.write_failed |->
            !result.tx_valid && (result.tx_byte == 8'h00) && !result.clear_answer)
        else $error("failure tick transmitted a byte");

    // After a failure the run restarts, so the next result cannot fail again.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && result.write_failed |=>
            !(result_valid && result.write_failed))
        else $error("two failures in a row");

    // A finished run restarts from the reset pulse, so the next result cannot finish again.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && result.write_done |=>
            !(result_valid && result.write_done))
        else $error("two run completions in a row");

endmodule

bind onewire_eeprom_block_writer owb_checker u_owb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
